FILE: hdl/mfgr_pkg.sv
// Shared types and constants of the monochrome framebuffer glyph renderer.
package mfgr_pkg;

  localparam int unsigned GlyphBytes = 1280;
  localparam int unsigned GlyphCols  = 5;
  localparam int unsigned CellCols   = 6;

  typedef enum logic [1:0] {
    CMD_PIXEL = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_FONT  = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIXEL,
    ST_DRAW,
    ST_FLUSH
  } state_e;

  // One framebuffer byte on its way to the output channel.
  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       last_byte;
  } out_beat_t;

endpackage

FILE: hdl/mfgr_out_buf.sv
// Two-entry output buffer that decouples framebuffer reads from a stalling receiver.
module mfgr_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mfgr_pkg::out_beat_t  push_beat_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output mfgr_pkg::out_beat_t  out_beat_o,
  output logic [1:0]           count_o
);

  mfgr_pkg::out_beat_t buf0_q, buf0_d, buf1_q, buf1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop         = (cnt_q != 2'd0) && !out_stall_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_beat_o  = buf0_q;
  assign count_o     = cnt_q;

  always_comb begin
    buf0_d = buf0_q;
    buf1_d = buf1_q;
    cnt_d  = cnt_q;
    case ({push_i, pop})
      2'b11: begin
        if (cnt_q == 2'd1) begin
          buf0_d = push_beat_i;
        end else begin
          buf0_d = buf1_q;
          buf1_d = push_beat_i;
        end
      end
      2'b01: begin
        buf0_d = buf1_q;
        cnt_d  = cnt_q - 2'd1;
      end
      2'b10: begin
        if (cnt_q == 2'd0) begin
          buf0_d = push_beat_i;
        end else begin
          buf1_d = push_beat_i;
        end
        cnt_d = cnt_q + 2'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf0_q <= buf0_d;
    buf1_q <= buf1_d;
  end

endmodule

FILE: hdl/mono_framebuffer_glyph_renderer.sv
// Page-organised monochrome framebuffer with a 5x8 glyph blitter and chunked readout.
//
// Commands arrive on the input channel (in_valid_i / in_stall_o); a transaction is
// taken when valid is high and stall is low. Flush results leave on the output
// channel (out_valid_o / out_stall_i) as one transaction per framebuffer byte.
// After reset the frame memory, SCREEN_WIDTH * ceil(SCREEN_HEIGHT / 8) bytes (1024 by
// default), is cleared one byte per cycle, which holds the input stalled until done.
// Command steps, set by the single read and single write port of the frame memory:
//   load font byte  - written in the accept cycle, next command may follow at once.
//   set pixel       - frame byte read, then the merged byte written back.
//   draw char       - two frame reads per cell column, glyph read overlapped with
//                     the first.
//   flush chunk     - one byte read per cycle while the output buffer has room; each
//                     byte passes the frame read register and the output buffer.
// A stalling receiver fills the two-entry output buffer, after which reads pause;
// no byte is lost or repeated. Commands stall until a flush has issued its last read.
module mono_framebuffer_glyph_renderer #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64,
  parameter int unsigned CHUNK_BYTES   = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic signed [8:0] pos_x_i,
  input  logic signed [8:0] pos_y_i,
  input  logic [7:0]        char_code_i,
  input  logic              fg_color_i,
  input  logic              bg_color_i,
  input  logic [10:0]       font_addr_i,
  input  logic [7:0]        font_data_i,
  input  logic [3:0]        chunk_index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        pixel_byte_o,
  output logic              last_byte_o
);

  localparam int unsigned Pages      = (SCREEN_HEIGHT + 7) / 8;
  localparam int unsigned FrameBytes = SCREEN_WIDTH * Pages;
  localparam int unsigned FaW        = $clog2(FrameBytes);
  localparam int unsigned FlaW       = $clog2(16 * CHUNK_BYTES);
  localparam int unsigned AddrW      = (FaW > FlaW) ? FaW : FlaW;
  localparam int unsigned KW         = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  localparam int unsigned LastRows   = SCREEN_HEIGHT - 8 * (Pages - 1);
  localparam logic [7:0]  LastMask   = 8'((16'd1 << LastRows) - 16'd1);

  // Storage
  logic [7:0] frame_mem [FrameBytes];
  logic [7:0] glyph_mem [mfgr_pkg::GlyphBytes];
  logic [7:0] frame_rdata_q;
  logic [7:0] glyph_rdata_q;

  logic           fr_we, fr_re;
  logic [FaW-1:0] fr_waddr, fr_raddr;
  logic [7:0]     fr_wdata;
  logic           gl_we, gl_re;
  logic [10:0]    gl_raddr;

  // Control
  mfgr_pkg::state_e state_q, state_d;
  logic             accept;
  logic [FaW-1:0]   clr_q, clr_d;
  logic [2:0]       col_q, col_d;
  logic             phase_q, phase_d;
  logic [KW-1:0]    k_q, k_d;
  logic [AddrW-1:0] fl_addr_q, fl_addr_d;

  // Latched command fields
  logic signed [8:0] px_q, py_q;
  logic [7:0]        code_q;
  logic              fg_q, bg_q;

  // Read-modify-write issue stage
  logic               iss_act, iss_ok, iss_phase, iss_pixel;
  logic [2:0]         iss_col;
  logic signed [9:0]  x_s;
  logic signed [6:0]  page_s;
  logic               x_ok, page_ok;
  logic [15:0]        cover16;
  logic [7:0]         cover_raw, row_mask;
  logic [FaW-1:0]     draw_addr;

  // Write-back stage
  logic           s2_valid_q;
  logic [FaW-1:0] s2_addr_q;
  logic [7:0]     s2_cover_q;
  logic           s2_phase_q, s2_blank_q, s2_pixel_q;
  logic [15:0]    g16;
  logic [7:0]     g8, wmask, colbits, merged;

  // Flush path
  logic                rd_vld_q, rd_zero_q, rd_last_q;
  logic                fl_issue, fl_inrange, fl_last, credit, pop;
  logic [1:0]          buf_count;
  mfgr_pkg::out_beat_t push_beat, out_beat;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != mfgr_pkg::ST_IDLE);

  // Issue stage address and mask for one frame byte of a pixel or a cell column.
  always_comb begin
    iss_act   = (state_q == mfgr_pkg::ST_PIXEL) || (state_q == mfgr_pkg::ST_DRAW);
    iss_pixel = (state_q == mfgr_pkg::ST_PIXEL);
    iss_phase = (state_q == mfgr_pkg::ST_DRAW) ? phase_q : 1'b0;
    iss_col   = (state_q == mfgr_pkg::ST_DRAW) ? col_q : 3'd0;
    x_s       = {px_q[8], px_q} + {7'd0, iss_col};
    page_s    = {py_q[8], py_q[8:3]} + {6'd0, iss_phase};
    x_ok      = (x_s >= 10'sd0) && (x_s < $signed(10'(SCREEN_WIDTH)));
    page_ok   = (page_s >= 7'sd0) && (page_s < $signed(7'(Pages)));
    iss_ok    = iss_act && x_ok && page_ok;
    cover16   = 16'h00FF << py_q[2:0];
    if (iss_pixel) begin
      cover_raw = 8'd1 << py_q[2:0];
    end else if (iss_phase) begin
      cover_raw = cover16[15:8];
    end else begin
      cover_raw = cover16[7:0];
    end
    row_mask  = (page_s[4:0] == 5'(Pages - 1)) ? LastMask : 8'hFF;
    draw_addr = FaW'(32'(x_s[7:0]) + 32'(page_s[4:0]) * 32'(SCREEN_WIDTH));
  end

  // Write-back: merge glyph bits into the byte read in the previous cycle.
  always_comb begin
    g16 = {8'd0, (s2_blank_q ? 8'd0 : glyph_rdata_q)} << py_q[2:0];
    if (s2_pixel_q) begin
      g8 = 8'hFF;
    end else if (s2_phase_q) begin
      g8 = g16[15:8];
    end else begin
      g8 = g16[7:0];
    end
    // Clear glyph bits are only painted when the background differs.
    wmask   = (bg_q != fg_q) ? s2_cover_q : (s2_cover_q & g8);
    colbits = (g8 & {8{fg_q}}) | (~g8 & {8{bg_q}});
    merged  = (frame_rdata_q & ~wmask) | (colbits & wmask);
  end

  // Flush read issue, limited by what the output buffer can still take.
  assign pop        = out_valid_o && !out_stall_i;
  assign credit     = ({1'b0, buf_count} + {2'd0, rd_vld_q}) < (3'd2 + {2'd0, pop});
  assign fl_issue   = (state_q == mfgr_pkg::ST_FLUSH) && credit;
  assign fl_inrange = 32'(fl_addr_q) < 32'(FrameBytes);
  assign fl_last    = (k_q == KW'(CHUNK_BYTES - 1));

  // Memory port selection
  always_comb begin
    if (state_q == mfgr_pkg::ST_CLEAR) begin
      fr_we    = 1'b1;
      fr_waddr = clr_q;
      fr_wdata = 8'd0;
    end else begin
      fr_we    = s2_valid_q;
      fr_waddr = s2_addr_q;
      fr_wdata = merged;
    end
    if (state_q == mfgr_pkg::ST_FLUSH) begin
      fr_re    = fl_issue && fl_inrange;
      fr_raddr = fl_addr_q[FaW-1:0];
    end else begin
      fr_re    = iss_ok;
      fr_raddr = draw_addr;
    end
    gl_we    = accept && (mfgr_pkg::cmd_e'(cmd_i) == mfgr_pkg::CMD_FONT) &&
               (32'(font_addr_i) < 32'(mfgr_pkg::GlyphBytes));
    gl_re    = (state_q == mfgr_pkg::ST_DRAW) && !phase_q &&
               (32'(col_q) < 32'(mfgr_pkg::GlyphCols));
    gl_raddr = {1'b0, code_q, 2'b00} + {3'd0, code_q} + {8'd0, col_q};
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    col_d     = col_q;
    phase_d   = phase_q;
    k_d       = k_q;
    fl_addr_d = fl_addr_q;
    unique case (state_q)
      mfgr_pkg::ST_CLEAR: begin
        clr_d = clr_q + FaW'(1);
        if (clr_q == FaW'(FrameBytes - 1)) begin
          state_d = mfgr_pkg::ST_IDLE;
        end
      end
      mfgr_pkg::ST_IDLE: begin
        col_d     = 3'd0;
        phase_d   = 1'b0;
        k_d       = '0;
        fl_addr_d = AddrW'(32'(chunk_index_i) * 32'(CHUNK_BYTES));
        if (accept) begin
          unique case (mfgr_pkg::cmd_e'(cmd_i))
            mfgr_pkg::CMD_PIXEL: state_d = mfgr_pkg::ST_PIXEL;
            mfgr_pkg::CMD_CHAR:  state_d = mfgr_pkg::ST_DRAW;
            mfgr_pkg::CMD_FLUSH: state_d = mfgr_pkg::ST_FLUSH;
            default:             state_d = mfgr_pkg::ST_IDLE;
          endcase
        end
      end
      mfgr_pkg::ST_PIXEL: begin
        state_d = mfgr_pkg::ST_IDLE;
      end
      mfgr_pkg::ST_DRAW: begin
        phase_d = !phase_q;
        if (phase_q) begin
          col_d = col_q + 3'd1;
          if (col_q == 3'(mfgr_pkg::CellCols - 1)) begin
            state_d = mfgr_pkg::ST_IDLE;
          end
        end
      end
      mfgr_pkg::ST_FLUSH: begin
        if (fl_issue) begin
          k_d       = k_q + KW'(1);
          fl_addr_d = fl_addr_q + AddrW'(1);
          if (fl_last) begin
            state_d = mfgr_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = mfgr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mfgr_pkg::ST_CLEAR;
      clr_q      <= '0;
      col_q      <= 3'd0;
      phase_q    <= 1'b0;
      k_q        <= '0;
      s2_valid_q <= 1'b0;
      rd_vld_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      col_q      <= col_d;
      phase_q    <= phase_d;
      k_q        <= k_d;
      s2_valid_q <= iss_ok;
      rd_vld_q   <= fl_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    fl_addr_q <= fl_addr_d;
    if (accept) begin
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      code_q <= char_code_i;
      fg_q   <= fg_color_i;
      bg_q   <= bg_color_i;
    end
    s2_addr_q  <= draw_addr;
    s2_cover_q <= cover_raw & row_mask;
    s2_phase_q <= iss_phase;
    s2_blank_q <= (iss_col == 3'(mfgr_pkg::CellCols - 1));
    s2_pixel_q <= iss_pixel;
    if (fl_issue) begin
      rd_zero_q <= !fl_inrange;
      rd_last_q <= fl_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fr_we) begin
      frame_mem[fr_waddr] <= fr_wdata;
    end
    if (fr_re) begin
      frame_rdata_q <= frame_mem[fr_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (gl_we) begin
      glyph_mem[font_addr_i] <= font_data_i;
    end
    if (gl_re) begin
      glyph_rdata_q <= glyph_mem[gl_raddr];
    end
  end

  // Bytes past the end of the framebuffer read as zero.
  assign push_beat.pixel_byte = rd_zero_q ? 8'd0 : frame_rdata_q;
  assign push_beat.last_byte  = rd_last_q;

  mfgr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rd_vld_q),
    .push_beat_i (push_beat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat),
    .count_o     (buf_count)
  );

  assign pixel_byte_o = out_beat.pixel_byte;
  assign last_byte_o  = out_beat.last_byte;

endmodule
